>>> rtl/wlbs_pkg.sv
package wlbs_pkg;

    // Field widths
    localparam int unsigned STEP_W  = 4;
    localparam int unsigned REQ_W   = 4;
    localparam int unsigned TACT_W  = 2;
    localparam int unsigned DLY_W   = 18;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned RDLY_W  = 8;
    localparam int unsigned APB_AW  = 5;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned RIDX_W  = 3;

    // Event kinds
    localparam logic [1:0] EV_TICK  = 2'd0;
    localparam logic [1:0] EV_AT    = 2'd1;
    localparam logic [1:0] EV_SMART = 2'd3;

    // Bring-up steps
    localparam logic [STEP_W-1:0] ST_POWER_OFF   = 4'd0;
    localparam logic [STEP_W-1:0] ST_POWER_ON    = 4'd1;
    localparam logic [STEP_W-1:0] ST_QUIT_TRANS  = 4'd2;
    localparam logic [STEP_W-1:0] ST_CLOSE_TRANS = 4'd3;
    localparam logic [STEP_W-1:0] ST_SMART_ON    = 4'd4;
    localparam logic [STEP_W-1:0] ST_SMART_WAIT  = 4'd5;
    localparam logic [STEP_W-1:0] ST_SMART_OFF   = 4'd6;
    localparam logic [STEP_W-1:0] ST_SET_STA     = 4'd7;
    localparam logic [STEP_W-1:0] ST_MOD_RST     = 4'd8;
    localparam logic [STEP_W-1:0] ST_ECHO_OFF    = 4'd9;
    localparam logic [STEP_W-1:0] ST_JOIN_AP     = 4'd10;
    localparam logic [STEP_W-1:0] ST_QUERY_AP    = 4'd11;
    localparam logic [STEP_W-1:0] ST_TCP_CONN    = 4'd12;
    localparam logic [STEP_W-1:0] ST_OPEN_TRANS  = 4'd13;
    localparam logic [STEP_W-1:0] ST_START_TRANS = 4'd14;
    localparam logic [STEP_W-1:0] ST_CONNECTED   = 4'd15;

    // AT requests (station mode to start send follow step - 3)
    localparam logic [REQ_W-1:0] AT_NONE        = 4'd0;
    localparam logic [REQ_W-1:0] AT_TRANS_OFF   = 4'd1;
    localparam logic [REQ_W-1:0] AT_SMART_START = 4'd2;
    localparam logic [REQ_W-1:0] AT_SMART_STOP  = 4'd3;
    localparam logic [REQ_W-1:0] AT_STEP_OFFSET = 4'd3;
    localparam logic [REQ_W-1:0] AT_ESCAPE      = 4'd12;

    // Link timer actions
    localparam logic [TACT_W-1:0] TA_NONE  = 2'd0;
    localparam logic [TACT_W-1:0] TA_START = 2'd1;
    localparam logic [TACT_W-1:0] TA_STOP  = 2'd2;

    // Register map
    localparam logic [RIDX_W-1:0] RI_GEN_LIM   = 3'd0;
    localparam logic [RIDX_W-1:0] RI_CONN_LIM  = 3'd1;
    localparam logic [RIDX_W-1:0] RI_REJOIN    = 3'd2;
    localparam logic [RIDX_W-1:0] RI_PWRCYCLE  = 3'd3;
    localparam logic [RIDX_W-1:0] RI_SMART_LIM = 3'd4;

    localparam logic [CNT_W-1:0] RST_GEN_LIM   = 5'd10;
    localparam logic [CNT_W-1:0] RST_CONN_LIM  = 5'd20;
    localparam logic [CNT_W-1:0] RST_REJOIN    = 5'd12;
    localparam logic [CNT_W-1:0] RST_PWRCYCLE  = 5'd24;
    localparam logic [CNT_W-1:0] RST_SMART_LIM = 5'd20;

    localparam logic [CNT_W-1:0] LIMIT_CAP = 5'd30;
    localparam logic [CNT_W-1:0] CNT_MAX   = 5'd31;

    typedef struct packed {
        logic [1:0]        cmd;
        logic              at_ok;
        logic              ap_joined;
        logic              smart_rx;
        logic              smart_parse_ok;
        logic [RDLY_W-1:0] reset_delay;
    } t_evt;

    typedef struct packed {
        logic [STEP_W-1:0] step_now;
        logic [REQ_W-1:0]  at_request;
        logic [TACT_W-1:0] timer_action;
        logic [DLY_W-1:0]  timer_delay;
        logic              abort_at;
        logic              store_credentials;
        logic              connected;
    } t_res;

    function automatic logic [CNT_W-1:0] clamp_lim(input logic [CNT_W-1:0] v);
        return (v > LIMIT_CAP) ? LIMIT_CAP : v;
    endfunction

endpackage

>>> rtl/wlbs_evt_if.sv
interface wlbs_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic       at_ok;
    logic       ap_joined;
    logic       smart_rx;
    logic       smart_parse_ok;
    logic [7:0] reset_delay;

    modport source (
        output valid, cmd, at_ok, ap_joined, smart_rx, smart_parse_ok, reset_delay,
        input  ready
    );
    modport sink (
        input  valid, cmd, at_ok, ap_joined, smart_rx, smart_parse_ok, reset_delay,
        output ready
    );
endinterface

>>> rtl/wlbs_res_if.sv
interface wlbs_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  step_now;
    logic [3:0]  at_request;
    logic [1:0]  timer_action;
    logic [17:0] timer_delay;
    logic        abort_at;
    logic        store_credentials;
    logic        connected;

    modport source (
        output valid, step_now, at_request, timer_action, timer_delay, abort_at,
               store_credentials, connected,
        input  ready
    );
    modport sink (
        input  valid, step_now, at_request, timer_action, timer_delay, abort_at,
               store_credentials, connected,
        output ready
    );
endinterface

>>> rtl/wifi_link_bringup_sequencer.sv
// Link bring-up sequencer for a wireless module.
// i_evt carries one event per transaction: link-timer tick, AT command
// result, reset request or smartconfig request. o_res returns exactly one
// result transaction per event: the new step, the AT request to issue, the
// link-timer action and delay, and the abort / store / connected flags.
// Limits are set over the APB port (5 registers at 4-byte spacing, write
// only while idle); reads return the current values.
// An accepted event is held in the input register, the step logic works on
// it, and the result is registered in the result register when that is
// empty or being emptied; o_res.valid rises with it.
// Throughput: one event per cycle while o_res is not stalled. The step,
// counters and flags update in the same cycle that a result is registered,
// so back-to-back events see the state left by their predecessor.
// Stall: while o_res is held (valid, not ready) the result register holds,
// the input register can still take one event, and i_evt.ready drops only
// when both are full.
// Reset (synchronous, active low): step goes to power off, all counters and
// flags clear, limits return to their defaults, both stages empty.
module wifi_link_bringup_sequencer #(
    parameter int unsigned TICKS_PER_SECOND = 1000,
    parameter int unsigned TICKS_PER_SHORT  = 100
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    wlbs_evt_if.sink                          i_evt,
    wlbs_res_if.source                        o_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [wlbs_pkg::APB_AW-1:0]       paddr,
    input  logic [wlbs_pkg::APB_DW-1:0]       pwdata,
    output logic [wlbs_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int unsigned DW = wlbs_pkg::DLY_W;
    localparam int unsigned CW = wlbs_pkg::CNT_W;

    // Timer delays in ticks
    localparam logic [DW-1:0] DLY_ONE     = DW'(1);
    localparam logic [DW-1:0] DLY_1S      = DW'(TICKS_PER_SECOND);
    localparam logic [DW-1:0] DLY_2S      = DW'(2 * TICKS_PER_SECOND);
    localparam logic [DW-1:0] DLY_3S      = DW'(3 * TICKS_PER_SECOND);
    localparam logic [DW-1:0] DLY_5S      = DW'(5 * TICKS_PER_SECOND);
    localparam logic [DW-1:0] DLY_10S     = DW'(10 * TICKS_PER_SECOND);
    localparam logic [DW-1:0] DLY_ESCAPE  = DW'(5 * TICKS_PER_SHORT);
    localparam logic [DW-1:0] DLY_BACKOFF = DW'(5 * TICKS_PER_SECOND);

    // ---------------- configuration registers ----------------
    logic [CW-1:0] r_gen_lim, r_conn_lim, r_rejoin, r_pwrcycle, r_smart_lim;
    logic [wlbs_pkg::RIDX_W-1:0] w_ridx;
    logic w_cfg_wr;

    assign pready   = 1'b1;
    assign w_ridx   = paddr[wlbs_pkg::APB_AW-1:2];
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_lim   <= wlbs_pkg::RST_GEN_LIM;
            r_conn_lim  <= wlbs_pkg::RST_CONN_LIM;
            r_rejoin    <= wlbs_pkg::RST_REJOIN;
            r_pwrcycle  <= wlbs_pkg::RST_PWRCYCLE;
            r_smart_lim <= wlbs_pkg::RST_SMART_LIM;
        end else if (w_cfg_wr) begin
            case (w_ridx)
                wlbs_pkg::RI_GEN_LIM:   r_gen_lim   <= pwdata[CW-1:0];
                wlbs_pkg::RI_CONN_LIM:  r_conn_lim  <= pwdata[CW-1:0];
                wlbs_pkg::RI_REJOIN:    r_rejoin    <= pwdata[CW-1:0];
                wlbs_pkg::RI_PWRCYCLE:  r_pwrcycle  <= pwdata[CW-1:0];
                wlbs_pkg::RI_SMART_LIM: r_smart_lim <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_ridx)
            wlbs_pkg::RI_GEN_LIM:   prdata[CW-1:0] = r_gen_lim;
            wlbs_pkg::RI_CONN_LIM:  prdata[CW-1:0] = r_conn_lim;
            wlbs_pkg::RI_REJOIN:    prdata[CW-1:0] = r_rejoin;
            wlbs_pkg::RI_PWRCYCLE:  prdata[CW-1:0] = r_pwrcycle;
            wlbs_pkg::RI_SMART_LIM: prdata[CW-1:0] = r_smart_lim;
            default:                prdata = '0;
        endcase
    end

    // ---------------- handshake and stage registers ----------------
    logic           r_in_valid, r_out_valid;
    wlbs_pkg::t_evt r_in;
    wlbs_pkg::t_res r_out, w_res;
    logic           w_adv, w_fire;

    // Stage advances when the result register is empty or being emptied
    assign w_adv      = !r_out_valid || o_res.ready;
    assign w_fire     = r_in_valid && w_adv;
    assign i_evt.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_evt.ready) begin
                r_in_valid <= i_evt.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_in.cmd            <= i_evt.cmd;
            r_in.at_ok          <= i_evt.at_ok;
            r_in.ap_joined      <= i_evt.ap_joined;
            r_in.smart_rx       <= i_evt.smart_rx;
            r_in.smart_parse_ok <= i_evt.smart_parse_ok;
            r_in.reset_delay    <= i_evt.reset_delay;
        end
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    // ---------------- sequencer state ----------------
    logic [wlbs_pkg::STEP_W-1:0] r_step, n_step;
    logic [CW-1:0] r_fc, n_fc, r_qc, n_qc, r_swc, n_swc;
    logic          r_se, n_se;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= wlbs_pkg::ST_POWER_OFF;
            r_fc   <= '0;
            r_qc   <= '0;
            r_se   <= 1'b0;
            r_swc  <= '0;
        end else if (w_fire) begin
            r_step <= n_step;
            r_fc   <= n_fc;
            r_qc   <= n_qc;
            r_se   <= n_se;
            r_swc  <= n_swc;
        end
    end

    // ---------------- step logic ----------------
    logic [CW-1:0] w_fc_inc, w_qc_inc, w_swc_inc, w_fail_lim;
    logic [DW-1:0] w_backoff;

    // Fail count saturates; query and smart-wait counts wrap
    assign w_fc_inc  = (r_fc == wlbs_pkg::CNT_MAX) ? r_fc : r_fc + CW'(1);
    assign w_qc_inc  = r_qc + CW'(1);
    assign w_swc_inc = r_swc + CW'(1);
    assign w_fail_lim = (r_step == wlbs_pkg::ST_TCP_CONN) ?
                        wlbs_pkg::clamp_lim(r_conn_lim) : wlbs_pkg::clamp_lim(r_gen_lim);
    // Backoff uses the incremented count even if a power cycle then clears it
    assign w_backoff = {{(DW-CW){1'b0}}, w_fc_inc} * DLY_BACKOFF;

    always_comb begin
        n_step = r_step;
        n_fc   = r_fc;
        n_qc   = r_qc;
        n_se   = r_se;
        n_swc  = r_swc;
        w_res  = '0;
        w_res.at_request   = wlbs_pkg::AT_NONE;
        w_res.timer_action = wlbs_pkg::TA_NONE;

        case (r_in.cmd)
            wlbs_pkg::EV_TICK: begin
                case (r_step)
                    wlbs_pkg::ST_POWER_OFF: begin
                        n_qc   = '0;
                        n_step = wlbs_pkg::ST_POWER_ON;
                        w_res.timer_action = wlbs_pkg::TA_START;
                        w_res.timer_delay  = DLY_1S;
                    end
                    wlbs_pkg::ST_POWER_ON: begin
                        n_step = wlbs_pkg::ST_QUIT_TRANS;
                        w_res.timer_action = wlbs_pkg::TA_START;
                        w_res.timer_delay  = DLY_1S;
                    end
                    wlbs_pkg::ST_QUIT_TRANS: begin
                        w_res.at_request   = wlbs_pkg::AT_ESCAPE;
                        n_step = wlbs_pkg::ST_CLOSE_TRANS;
                        w_res.timer_action = wlbs_pkg::TA_START;
                        w_res.timer_delay  = DLY_ESCAPE;
                    end
                    wlbs_pkg::ST_SMART_WAIT: begin
                        w_res.timer_action = wlbs_pkg::TA_START;
                        w_res.timer_delay  = DLY_3S;
                        if (r_in.smart_rx) begin
                            w_res.store_credentials = r_in.smart_parse_ok;
                            n_swc  = '0;
                            n_se   = 1'b0;
                            n_step = wlbs_pkg::ST_SMART_OFF;
                            w_res.timer_delay = DLY_5S;
                        end else if (r_swc > wlbs_pkg::clamp_lim(r_smart_lim)) begin
                            n_swc  = '0;
                            n_se   = 1'b0;
                            n_step = wlbs_pkg::ST_SMART_OFF;
                            w_res.timer_delay = DLY_5S;
                        end else begin
                            n_swc = w_swc_inc;
                        end
                    end
                    wlbs_pkg::ST_CONNECTED: begin
                        w_res.timer_action = wlbs_pkg::TA_STOP;
                    end
                    wlbs_pkg::ST_CLOSE_TRANS: begin
                        w_res.at_request   = wlbs_pkg::AT_TRANS_OFF;
                        w_res.timer_action = wlbs_pkg::TA_STOP;
                    end
                    wlbs_pkg::ST_SMART_ON: begin
                        w_res.at_request   = wlbs_pkg::AT_SMART_START;
                        w_res.timer_action = wlbs_pkg::TA_STOP;
                    end
                    wlbs_pkg::ST_SMART_OFF: begin
                        w_res.at_request   = wlbs_pkg::AT_SMART_STOP;
                        w_res.timer_action = wlbs_pkg::TA_STOP;
                    end
                    default: begin
                        // station mode .. start send
                        w_res.at_request   = r_step - wlbs_pkg::AT_STEP_OFFSET;
                        w_res.timer_action = wlbs_pkg::TA_STOP;
                    end
                endcase
            end

            wlbs_pkg::EV_AT: begin
                if (r_in.at_ok) begin
                    n_fc = '0;
                    w_res.timer_action = wlbs_pkg::TA_START;
                    w_res.timer_delay  = DLY_ONE;
                    case (r_step)
                        wlbs_pkg::ST_CLOSE_TRANS:
                            n_step = r_se ? wlbs_pkg::ST_SMART_ON : wlbs_pkg::ST_SET_STA;
                        wlbs_pkg::ST_SMART_ON:  n_step = wlbs_pkg::ST_SMART_WAIT;
                        wlbs_pkg::ST_SMART_OFF: n_step = wlbs_pkg::ST_SET_STA;
                        wlbs_pkg::ST_SET_STA:   n_step = wlbs_pkg::ST_MOD_RST;
                        wlbs_pkg::ST_MOD_RST: begin
                            n_step = wlbs_pkg::ST_ECHO_OFF;
                            w_res.timer_delay = DLY_2S;
                        end
                        wlbs_pkg::ST_ECHO_OFF:  n_step = wlbs_pkg::ST_JOIN_AP;
                        wlbs_pkg::ST_JOIN_AP:   n_step = wlbs_pkg::ST_QUERY_AP;
                        wlbs_pkg::ST_QUERY_AP: begin
                            if (r_in.ap_joined) begin
                                n_step = wlbs_pkg::ST_TCP_CONN;
                            end else begin
                                w_res.timer_delay = DLY_10S;
                                n_qc = w_qc_inc;
                                if (w_qc_inc == r_rejoin) begin
                                    n_step = wlbs_pkg::ST_JOIN_AP;
                                end else if (w_qc_inc == r_pwrcycle) begin
                                    n_step = wlbs_pkg::ST_POWER_OFF;
                                end
                            end
                        end
                        wlbs_pkg::ST_TCP_CONN:    n_step = wlbs_pkg::ST_OPEN_TRANS;
                        wlbs_pkg::ST_OPEN_TRANS:  n_step = wlbs_pkg::ST_START_TRANS;
                        wlbs_pkg::ST_START_TRANS: n_step = wlbs_pkg::ST_CONNECTED;
                        default: ;
                    endcase
                end else if (r_step == wlbs_pkg::ST_JOIN_AP) begin
                    // join failure goes straight on to the query
                    n_step = wlbs_pkg::ST_QUERY_AP;
                    w_res.timer_action = wlbs_pkg::TA_START;
                    w_res.timer_delay  = DLY_ONE;
                end else begin
                    n_fc = w_fc_inc;
                    w_res.timer_action = wlbs_pkg::TA_START;
                    w_res.timer_delay  = w_backoff;
                    if (w_fc_inc > w_fail_lim) begin
                        n_fc   = '0;
                        n_step = wlbs_pkg::ST_POWER_OFF;
                    end
                end
            end

            default: begin
                // reset or smartconfig request
                n_step = wlbs_pkg::ST_POWER_OFF;
                n_fc   = '0;
                w_res.abort_at     = 1'b1;
                w_res.timer_action = wlbs_pkg::TA_START;
                if (r_in.cmd == wlbs_pkg::EV_SMART) begin
                    n_se = 1'b1;
                    w_res.timer_delay = DLY_ONE;
                end else begin
                    w_res.timer_delay = {{(DW-wlbs_pkg::RDLY_W){1'b0}}, r_in.reset_delay};
                end
            end
        endcase

        w_res.step_now  = n_step;
        w_res.connected = (n_step == wlbs_pkg::ST_CONNECTED);
    end

    // ---------------- result channel ----------------
    assign o_res.valid             = r_out_valid;
    assign o_res.step_now          = r_out.step_now;
    assign o_res.at_request        = r_out.at_request;
    assign o_res.timer_action      = r_out.timer_action;
    assign o_res.timer_delay       = r_out.timer_delay;
    assign o_res.abort_at          = r_out.abort_at;
    assign o_res.store_credentials = r_out.store_credentials;
    assign o_res.connected         = r_out.connected;

endmodule

>>> rtl/wlbs_checker.sv
module wlbs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [3:0]  i_step_now,
    input logic [3:0]  i_at_request,
    input logic [1:0]  i_timer_action,
    input logic [17:0] i_timer_delay,
    input logic        i_abort_at,
    input logic        i_store_credentials,
    input logic        i_connected
);

    // connected flag tracks the final step
    a_connected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_connected == (i_step_now == wlbs_pkg::ST_CONNECTED)))
        else $error("connected flag disagrees with step");

    // delay only meaningful on a timer start
    a_delay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_timer_action != wlbs_pkg::TA_START)) |-> (i_timer_delay == '0))
        else $error("timer delay without timer start");

    // abort always lands in power off with a restart of the timer
    a_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_abort_at) |->
            ((i_step_now == wlbs_pkg::ST_POWER_OFF) &&
             (i_timer_action == wlbs_pkg::TA_START) &&
             (i_at_request == wlbs_pkg::AT_NONE)))
        else $error("abort result malformed");

    // credentials saved only on leaving smart wait
    a_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_store_credentials) |-> (i_step_now == wlbs_pkg::ST_SMART_OFF))
        else $error("store credentials outside smart off");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=>
            (i_valid && $stable(i_step_now) && $stable(i_at_request) &&
             $stable(i_timer_action) && $stable(i_timer_delay) &&
             $stable(i_abort_at) && $stable(i_store_credentials)))
        else $error("result changed while stalled");

endmodule

bind wifi_link_bringup_sequencer wlbs_checker u_wlbs_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (o_res.valid),
    .i_ready             (o_res.ready),
    .i_step_now          (o_res.step_now),
    .i_at_request        (o_res.at_request),
    .i_timer_action      (o_res.timer_action),
    .i_timer_delay       (o_res.timer_delay),
    .i_abort_at          (o_res.abort_at),
    .i_store_credentials (o_res.store_credentials),
    .i_connected         (o_res.connected)
);
